// ----- rtl/incremental_bounding_sphere_core_macros.svh -----
// Assertion macros for the bounding sphere core.
// Used by modules clocked on i_clk with the active-low reset i_rst_n.
`ifndef INCREMENTAL_BOUNDING_SPHERE_CORE_MACROS_SVH
`define INCREMENTAL_BOUNDING_SPHERE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define IBS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check.
`define IBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IBS_ASSERT_IMPL(lbl, ante, cons, msg)
`define IBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/ibs_pkg.sv -----
// Shared types, widths and helpers for the bounding sphere core.
// No dependencies.
package ibs_pkg;

    localparam int COORD_W  = 32;
    localparam int DELTA_W  = 33;
    localparam int RADIUS_W = 33;
    localparam int PROD_W   = 66;
    localparam int DEN_W    = 34;
    localparam int QUOT_W   = 34;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_CMP,
        ST_UP_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_UP_ADD,
        ST_FINISH
    } t_state;

    // Status of an iterative unit: busy while iterating, done for one cycle.
    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

    // Magnitude of a signed offset; fits unsigned in the same width.
    function automatic logic [DELTA_W-1:0] mag33(input logic signed [DELTA_W-1:0] v);
        logic [DELTA_W-1:0] r;
        r = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
        return r;
    endfunction

    // Clamp a widened sum to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/incremental_bounding_sphere_core.sv -----
// Top level of the streaming bounding sphere core: sequencer, shared multiplier.
// Depends on ibs_pkg, ibs_sqrt, ibs_div and the core macros header.
//
//   channel   direction  handshake            payload
//   vertex    in         i_valid / o_ready    i_vertex_x/y/z, i_last_vertex
//   sphere    out        o_valid / i_ready    o_center_x/y/z, o_sphere_radius,
//                                             o_sphere_valid
//
// Every vertex runs the 33-step square root; one that grows the sphere also runs
// three 66-step divisions, one per axis. Reset is synchronous and clears the sphere
// to the origin with radius zero.
// o_ready is high only while the sequencer is idle; a waiting result does not
// block the next vertex unless that vertex also closes a set.
`include "incremental_bounding_sphere_core_macros.svh"
module incremental_bounding_sphere_core import ibs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [COORD_W-1:0]  i_vertex_x,
    input  logic signed [COORD_W-1:0]  i_vertex_y,
    input  logic signed [COORD_W-1:0]  i_vertex_z,
    input  logic                       i_last_vertex,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [COORD_W-1:0]  o_center_x,
    output logic signed [COORD_W-1:0]  o_center_y,
    output logic signed [COORD_W-1:0]  o_center_z,
    output logic [RADIUS_W-1:0]        o_sphere_radius,
    output logic                       o_sphere_valid
);

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_center [3];
    logic signed [DELTA_W-1:0] r_delta [3];
    logic [RADIUS_W-1:0]       r_radius;
    logic [RADIUS_W-1:0]       r_dist;
    logic [RADIUS_W-1:0]       r_grow;
    logic [PROD_W-1:0]         r_prod;
    logic [PROD_W-1:0]         r_acc;
    logic [1:0]                r_axis;
    logic                      r_last;
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_out_c [3];
    logic [RADIUS_W-1:0]       r_out_radius;

    logic                      w_accept;
    logic                      w_emit;
    logic [DELTA_W-1:0]        w_mag;
    logic [DELTA_W-1:0]        w_mul_b;
    logic [RADIUS_W-1:0]       w_root;
    logic [QUOT_W-1:0]         w_quot;
    logic signed [35:0]        w_cext;
    logic signed [35:0]        w_qext;
    logic signed [35:0]        w_moved;
    logic [RADIUS_W:0]         w_rsum;
    t_iter_stat                w_sqrt_stat;
    t_iter_stat                w_div_stat;
    logic                      w_sqrt_go;
    logic                      w_div_go;

    assign w_accept = i_valid && o_ready;
    assign w_emit   = (r_state == ST_FINISH) && r_last && (!r_out_valid || i_ready);

    // Shared multiplier operands: squares first, then offset times growth.
    assign w_mag   = mag33(r_delta[r_axis]);
    assign w_mul_b = (r_state == ST_UP_MUL) ? r_grow : w_mag;

    // Center move for the current axis, toward the vertex.
    assign w_cext  = 36'(r_center[r_axis]);
    assign w_qext  = $signed({2'b00, w_quot});
    assign w_moved = r_delta[r_axis][DELTA_W-1] ? (w_cext - w_qext) : (w_cext + w_qext);
    assign w_rsum  = {1'b0, r_radius} + {1'b0, r_dist};

    ibs_sqrt u_sqrt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_sqrt_go),
        .i_radicand     (r_acc),
        .o_root         (w_root),
        .o_stat         (w_sqrt_stat)
    );

    ibs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_go),
        .i_num  (r_prod),
        .i_den  ({r_dist, 1'b0}),
        .o_quot (w_quot),
        .o_stat (w_div_stat)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and unit strobes.
    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        w_sqrt_go = 1'b0;
        w_div_go  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: n_state = ST_SQ_ACC;
            ST_SQ_ACC: n_state = (r_axis == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
            ST_SQRT_GO: begin
                w_sqrt_go = 1'b1;
                n_state   = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (w_sqrt_stat.done) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: n_state = (r_dist > r_radius) ? ST_UP_MUL : ST_FINISH;
            ST_UP_MUL: n_state = ST_DIV_GO;
            ST_DIV_GO: begin
                w_div_go = 1'b1;
                n_state  = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = ST_UP_ADD;
                end
            end
            ST_UP_ADD: n_state = (r_axis == 2'd2) ? ST_FINISH : ST_UP_MUL;
            ST_FINISH: begin
                if (!r_last || w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sphere state, output register and step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_radius    <= '0;
            r_out_valid <= 1'b0;
            r_axis      <= '0;
        end else begin
            case (r_state)
                ST_IDLE: r_axis <= '0;
                ST_SQ_ACC: r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                ST_UP_ADD: begin
                    r_center[r_axis] <= sat32(w_moved);
                    r_axis           <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    if (r_axis == 2'd2) begin
                        r_radius <= w_rsum[RADIUS_W:1];
                    end
                end
                default: ;
            endcase
            // Close the set: publish the sphere, then start over at the origin.
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_center[0] <= '0;
                r_center[1] <= '0;
                r_center[2] <= '0;
                r_radius    <= '0;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers that need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_delta[0] <= DELTA_W'(i_vertex_x) - DELTA_W'(r_center[0]);
            r_delta[1] <= DELTA_W'(i_vertex_y) - DELTA_W'(r_center[1]);
            r_delta[2] <= DELTA_W'(i_vertex_z) - DELTA_W'(r_center[2]);
            r_last     <= i_last_vertex;
            r_acc      <= '0;
        end
        if (r_state == ST_SQ_MUL || r_state == ST_UP_MUL) begin
            r_prod <= w_mag * w_mul_b;
        end
        if (r_state == ST_SQ_ACC) begin
            r_acc <= r_acc + r_prod;
        end
        if (w_sqrt_stat.done) begin
            r_dist <= w_root;
        end
        if (r_state == ST_CMP) begin
            r_grow <= r_dist - r_radius;
        end
        if (w_emit) begin
            r_out_c[0]   <= r_center[0];
            r_out_c[1]   <= r_center[1];
            r_out_c[2]   <= r_center[2];
            r_out_radius <= r_radius;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_center_x      = r_out_c[0];
    assign o_center_y      = r_out_c[1];
    assign o_center_z      = r_out_c[2];
    assign o_sphere_radius = r_out_radius;
    assign o_sphere_valid  = (r_out_radius != '0);

    `IBS_ASSERT_IMPL(a_sqrt_free, w_sqrt_go, !w_sqrt_stat.busy, "square root started while busy")
    `IBS_ASSERT_IMPL(a_div_free, w_div_go, !w_div_stat.busy && (r_dist != '0), "division started while busy or by zero")
    `IBS_ASSERT_NEXT(a_emit_clears, w_emit, r_out_valid && (r_radius == '0) && (r_center[0] == '0), "sphere not cleared after a result")
    `IBS_ASSERT_IMPL(a_emit_slot, w_emit, !r_out_valid || i_ready, "result overwrote a pending transfer")

endmodule

// ----- rtl/ibs_sqrt.sv -----
// Iterative floor square root of a 66-bit value, two radicand bits per cycle.
// Depends on ibs_pkg.
module ibs_sqrt import ibs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_radicand,
    output logic [RADIUS_W-1:0] o_root,
    output t_iter_stat         o_stat
);

    logic [PROD_W-1:0]   r_rad;
    logic [33:0]         r_rem;
    logic [RADIUS_W-1:0] r_root;
    logic [5:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [35:0]         w_rem_sh;
    logic [35:0]         w_trial;
    logic                w_ge;

    // One restoring step: bring down two bits and try a one in the root.
    assign w_rem_sh = {r_rem, r_rad[PROD_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[PROD_W-3:0], 2'b00};
            if (w_ge) begin
                r_rem  <= 34'(w_rem_sh - w_trial);
                r_root <= {r_root[RADIUS_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[33:0];
                r_root <= {r_root[RADIUS_W-2:0], 1'b0};
            end
        end
    end

    assign o_root          = r_root;
    assign o_stat          = '{busy: r_busy, done: r_done};

endmodule

// ----- rtl/ibs_div.sv -----
// Iterative restoring divider: 66-bit dividend by 34-bit divisor, one bit a cycle.
// Keeps the low 34 quotient bits. Depends on ibs_pkg.
module ibs_div import ibs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [QUOT_W-1:0] o_quot,
    output t_iter_stat        o_stat
);

    logic [PROD_W-1:0] r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic [6:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    w_rem_sh;
    logic              w_ge;

    // Bring down the next dividend bit and compare with the divisor.
    assign w_rem_sh = {r_rem, r_num[PROD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(PROD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[PROD_W-2:0], 1'b0};
            if (w_ge) begin
                r_rem  <= DEN_W'(w_rem_sh - {1'b0, r_den});
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[DEN_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_quot;
    assign o_stat = '{busy: r_busy, done: r_done};

endmodule

// ----- tb/incremental_bounding_sphere_core_tb.sv -----
// Self-checking testbench for incremental_bounding_sphere_core.
// Depends on ibs_pkg and the core RTL; a sphere predictor checks every result transfer.
module incremental_bounding_sphere_core_tb;
    import ibs_pkg::*;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } t_vertex;

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RADIUS_W-1:0]       radius;
        logic                      valid;
    } t_sphere;

    localparam logic [RADIUS_W-1:0] RADIUS_SAT = {RADIUS_W{1'b1}};
    localparam int SETTLE_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic signed [COORD_W-1:0] i_vertex_x;
    logic signed [COORD_W-1:0] i_vertex_y;
    logic signed [COORD_W-1:0] i_vertex_z;
    logic i_last_vertex;
    logic o_valid;
    logic i_ready;
    logic signed [COORD_W-1:0] o_center_x;
    logic signed [COORD_W-1:0] o_center_y;
    logic signed [COORD_W-1:0] o_center_z;
    logic [RADIUS_W-1:0] o_sphere_radius;
    logic o_sphere_valid;

    t_vertex vertex_queue[$];
    t_sphere sphere_queue[$];
    int      mismatch_count = 0;
    bit      stimulus_done = 0;

    // Running sphere of the predictor.
    logic signed [COORD_W-1:0] pred_cx;
    logic signed [COORD_W-1:0] pred_cy;
    logic signed [COORD_W-1:0] pred_cz;
    logic [RADIUS_W-1:0]       pred_radius;

    incremental_bounding_sphere_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y), .i_vertex_z(i_vertex_z),
        .i_last_vertex(i_last_vertex),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_center_x(o_center_x), .o_center_y(o_center_y), .o_center_z(o_center_z),
        .o_sphere_radius(o_sphere_radius), .o_sphere_valid(o_sphere_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor square root of a 66-bit squared length.
    function automatic logic [33:0] floor_sqrt(input logic [65:0] sq);
        logic [33:0] root;
        logic [33:0] cand;
        logic [67:0] cand_sq;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            cand_sq = 68'(cand) * 68'(cand);
            if (cand_sq <= {2'b00, sq}) root = cand;
        end
        return root;
    endfunction

    // Move one center coordinate toward the vertex by trunc(delta*grow/(2d)).
    function automatic logic signed [COORD_W-1:0] shift_coord(
        input logic signed [COORD_W-1:0] c, input logic signed [32:0] delta,
        input logic [33:0] grow, input logic [33:0] distance);
        logic [32:0]         amag;
        logic [127:0]        prod;
        logic [127:0]        quot;
        logic signed [39:0]  sum;
        amag = delta[32] ? 33'(-delta) : 33'(delta);
        prod = 128'(amag) * 128'(grow);
        quot = prod / (128'(distance) << 1);
        quot = quot & 128'h3_FFFF_FFFF;
        if (delta[32]) sum = 40'(c) - $signed({6'b0, quot[33:0]});
        else sum = 40'(c) + $signed({6'b0, quot[33:0]});
        if (sum > 40'sd2147483647) return 32'sh7FFF_FFFF;
        if (sum < -40'sd2147483648) return 32'sh8000_0000;
        return sum[31:0];
    endfunction

    // Fold one accepted vertex into the predicted sphere; queue a result on the last one.
    task automatic fold_vertex(input t_vertex v);
        logic signed [32:0] dx, dy, dz;
        logic [65:0]        ax, ay, az;
        logic [65:0]        sq;
        logic [33:0]        distance, grow, half;
        t_sphere            res;
        dx = 33'(v.x) - 33'(pred_cx);
        dy = 33'(v.y) - 33'(pred_cy);
        dz = 33'(v.z) - 33'(pred_cz);
        ax = dx[32] ? 66'(33'(-dx)) : 66'(33'(dx));
        ay = dy[32] ? 66'(33'(-dy)) : 66'(33'(dy));
        az = dz[32] ? 66'(33'(-dz)) : 66'(33'(dz));
        sq = ax * ax + ay * ay + az * az;
        distance = floor_sqrt(sq);
        if (distance > 34'(pred_radius)) begin
            grow = distance - 34'(pred_radius);
            half = 34'((35'(pred_radius) + 35'(distance)) >> 1);
            pred_cx = shift_coord(pred_cx, dx, grow, distance);
            pred_cy = shift_coord(pred_cy, dy, grow, distance);
            pred_cz = shift_coord(pred_cz, dz, grow, distance);
            pred_radius = (half > 34'(RADIUS_SAT)) ? RADIUS_SAT : half[32:0];
        end
        if (v.last) begin
            res.cx = pred_cx;
            res.cy = pred_cy;
            res.cz = pred_cz;
            res.radius = pred_radius;
            res.valid = (pred_radius != '0);
            sphere_queue.push_back(res);
            pred_cx = '0;
            pred_cy = '0;
            pred_cz = '0;
            pred_radius = '0;
        end
    endtask

    // Random coordinate: full range, small near the origin, or an extreme.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom;
        if (sel < 8) return $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
        case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return 32'shFFFF_FFFF;
        endcase
    endfunction

    task automatic add_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic last);
        t_vertex v;
        v.x = x; v.y = y; v.z = z; v.last = last;
        vertex_queue.push_back(v);
    endtask

    // Stimulus: directed sets first, then random sets of random length.
    initial begin
        int n;
        int set_len;
        // Empty set: a lone vertex at the origin gives an invalid sphere.
        add_vertex(0, 0, 0, 1'b1);
        // Extremes on opposite corners.
        add_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        add_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        add_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        add_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        // Growth, then a vertex inside and one exactly on the sphere.
        add_vertex(32'sh0010_0000, 0, 0, 1'b0);
        add_vertex(32'sh0001_0000, 32'sh0001_0000, 0, 1'b0);
        add_vertex(0, 0, 0, 1'b1);
        // Single-axis negatives and tiny offsets.
        add_vertex(-32'sd1, 0, 0, 1'b0);
        add_vertex(0, -32'sd1, 0, 1'b0);
        add_vertex(0, 0, -32'sd1, 1'b0);
        add_vertex(0, 0, 32'sd1, 1'b1);
        add_vertex(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
        add_vertex(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1);
        // One vertex repeated: the second adds nothing.
        add_vertex(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ABCD, 1'b0);
        add_vertex(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_ABCD, 1'b1);
        n = 16;
        while (n < 866) begin
            set_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 10);
            for (int k = 0; k < set_len; k++) begin
                add_vertex(pick_coord(), pick_coord(), pick_coord(), k == set_len - 1);
                n++;
            end
        end
        stimulus_done = 1;
    end

    // Vertex driver: random gap before each item, valid held until the transfer.
    int send_gap;
    always @(posedge i_clk) begin
        t_vertex v;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= $urandom_range(0, 17);
        end else if (i_valid && !o_ready) begin
            // Hold the item.
        end else begin
            if (i_valid) begin
                v.x = i_vertex_x; v.y = i_vertex_y; v.z = i_vertex_z;
                v.last = i_last_vertex;
                fold_vertex(v);
            end
            if ((i_valid ? ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 17))
                         : send_gap) == 0 && vertex_queue.size() > 0) begin
                v = vertex_queue.pop_front();
                i_vertex_x <= v.x;
                i_vertex_y <= v.y;
                i_vertex_z <= v.z;
                i_last_vertex <= v.last;
                i_valid <= 1'b1;
                send_gap <= $urandom_range(0, 17);
            end else begin
                i_valid <= 1'b0;
                if (!i_valid && send_gap > 0) send_gap <= send_gap - 1;
            end
        end
    end

    // Result monitor: random stall before each transfer, then a field-by-field check.
    int recv_gap;
    always @(posedge i_clk) begin
        t_sphere e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_gap <= $urandom_range(0, 17);
        end else begin
            if (o_valid && i_ready) begin
                if (sphere_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected sphere transfer: c=(%0d,%0d,%0d) r=%0d v=%0b",
                                 o_center_x, o_center_y, o_center_z, o_sphere_radius,
                                 o_sphere_valid);
                end else begin
                    e = sphere_queue.pop_front();
                    if (o_center_x !== e.cx || o_center_y !== e.cy || o_center_z !== e.cz ||
                        o_sphere_radius !== e.radius || o_sphere_valid !== e.valid) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("sphere mismatch: exp c=(%0d,%0d,%0d) r=%0d v=%0b, got c=(%0d,%0d,%0d) r=%0d v=%0b",
                                     e.cx, e.cy, e.cz, e.radius, e.valid,
                                     o_center_x, o_center_y, o_center_z,
                                     o_sphere_radius, o_sphere_valid);
                    end
                end
                recv_gap <= $urandom_range(0, 17);
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                i_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Reset, then wait for all transfers to drain and report.
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_vertex_x = '0;
        i_vertex_y = '0;
        i_vertex_z = '0;
        i_last_vertex = 1'b0;
        pred_cx = '0;
        pred_cy = '0;
        pred_cz = '0;
        pred_radius = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done);
        @(posedge i_clk);
        // Sample between edges so the driver and monitor updates have settled.
        @(negedge i_clk);
        while (vertex_queue.size() > 0 || i_valid || sphere_queue.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && sphere_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(20 * 2000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
